// ===== src/bcgd_pkg.sv =====
package bcgd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned MaxW   = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MULTI  = 2'd3;

  localparam logic [MsW-1:0]  DebounceRst  = 16'd50;
  localparam logic [MsW-1:0]  LongPressRst = 16'd1000;
  localparam logic [MsW-1:0]  DoubleRst    = 16'd250;
  localparam logic [MaxW-1:0] MaxMultiRst  = 8'd3;

  // sticky event flag bit positions
  localparam int unsigned EV_CLICK  = 0;
  localparam int unsigned EV_DOUBLE = 1;
  localparam int unsigned EV_LONG   = 2;
  localparam int unsigned EV_MULTI  = 3;
  localparam int unsigned EvW       = 4;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_DEB_PRESS = 3'd1,
    MODE_PRESSED   = 3'd2,
    MODE_WAIT_REL  = 3'd3,
    MODE_DEB_REL   = 3'd4,
    MODE_WAIT_NEXT = 3'd5
  } mode_e;

  typedef struct packed {
    logic [MsW-1:0]  debounce_ms;
    logic [MsW-1:0]  long_press_ms;
    logic [MsW-1:0]  double_click_ms;
    logic [MaxW-1:0] max_multi_clicks;
  } cfg_t;

  typedef struct packed {
    logic             pressed;
    logic [TimeW-1:0] now_ms;
    logic             clear_events;
  } poll_t;

  typedef struct packed {
    logic              is_pressed;
    logic              is_long_press;
    logic [CountW-1:0] click_count;
    logic              click_event;
    logic              double_click_event;
    logic              long_press_event;
    logic              multi_click_event;
  } result_t;

endpackage

// ===== src/bcgd_poll_if.sv =====
interface bcgd_poll_if;
  logic                       valid;
  logic                       ready;
  logic                       pressed;
  logic [bcgd_pkg::TimeW-1:0] now_ms;
  logic                       clear_events;

  modport source (output valid, output pressed, output now_ms, output clear_events,
                  input ready);
  modport sink (input valid, input pressed, input now_ms, input clear_events,
                output ready);
endinterface

// ===== src/bcgd_result_if.sv =====
interface bcgd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        is_pressed;
  logic                        is_long_press;
  logic [bcgd_pkg::CountW-1:0] click_count;
  logic                        click_event;
  logic                        double_click_event;
  logic                        long_press_event;
  logic                        multi_click_event;

  modport source (output valid, output is_pressed, output is_long_press,
                  output click_count, output click_event, output double_click_event,
                  output long_press_event, output multi_click_event, input ready);
  modport sink (input valid, input is_pressed, input is_long_press,
                input click_count, input click_event, input double_click_event,
                input long_press_event, input multi_click_event, output ready);
endinterface

// ===== src/bcgd_cfg.sv =====
module bcgd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcgd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcgd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bcgd_pkg::cfg_t                 cfg_o
);

  bcgd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcgd_pkg::CFG_DEBOUNCE:   cfg_d.debounce_ms     = cfg_wdata_i;
        bcgd_pkg::CFG_LONG_PRESS: cfg_d.long_press_ms   = cfg_wdata_i;
        bcgd_pkg::CFG_DOUBLE:     cfg_d.double_click_ms = cfg_wdata_i;
        bcgd_pkg::CFG_MAX_MULTI:  cfg_d.max_multi_clicks = cfg_wdata_i[bcgd_pkg::MaxW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= bcgd_pkg::DebounceRst;
      cfg_q.long_press_ms    <= bcgd_pkg::LongPressRst;
      cfg_q.double_click_ms  <= bcgd_pkg::DoubleRst;
      cfg_q.max_multi_clicks <= bcgd_pkg::MaxMultiRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bcgd_fsm.sv =====
module bcgd_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bcgd_pkg::poll_t   poll_i,
  input  bcgd_pkg::cfg_t    cfg_i,
  output bcgd_pkg::result_t result_o
);

  bcgd_pkg::mode_e                 mode_q, mode_d;
  logic [bcgd_pkg::TimeW-1:0]      entered_at_q, entered_at_d;
  logic [bcgd_pkg::TimeW-1:0]      press_at_q, press_at_d;
  logic [bcgd_pkg::TimeW-1:0]      released_at_q, released_at_d;
  logic [bcgd_pkg::CountW-1:0]     clicks_q, clicks_d;
  logic                            held_q, held_d;
  logic                            long_q, long_d;
  logic [bcgd_pkg::EvW-1:0]        ev_q, ev_d;

  logic [bcgd_pkg::TimeW-1:0]      since_enter, since_press, since_release;
  logic                            deb_done, long_done, gap_done;
  logic [bcgd_pkg::CountW-1:0]     clicks_inc;

  // wrap-around elapsed times
  assign since_enter   = poll_i.now_ms - entered_at_q;
  assign since_press   = poll_i.now_ms - press_at_q;
  assign since_release = poll_i.now_ms - released_at_q;
  assign deb_done  = since_enter >= {{(bcgd_pkg::TimeW-bcgd_pkg::MsW){1'b0}}, cfg_i.debounce_ms};
  assign long_done = since_press >= {{(bcgd_pkg::TimeW-bcgd_pkg::MsW){1'b0}}, cfg_i.long_press_ms};
  assign gap_done  = since_release >=
                     {{(bcgd_pkg::TimeW-bcgd_pkg::MsW){1'b0}}, cfg_i.double_click_ms};
  assign clicks_inc = clicks_q + 9'd1;

  always_comb begin
    mode_d        = mode_q;
    entered_at_d  = entered_at_q;
    press_at_d    = press_at_q;
    released_at_d = released_at_q;
    clicks_d      = clicks_q;
    held_d        = held_q;
    long_d        = long_q;
    ev_d          = poll_i.clear_events ? '0 : ev_q;

    unique case (mode_q)
      bcgd_pkg::MODE_DEB_PRESS: begin
        if (deb_done) begin
          entered_at_d = poll_i.now_ms;
          if (poll_i.pressed) begin
            press_at_d = poll_i.now_ms;
            held_d     = 1'b1;
            mode_d     = bcgd_pkg::MODE_PRESSED;
          end else begin
            mode_d = bcgd_pkg::MODE_IDLE;
          end
        end
      end
      bcgd_pkg::MODE_PRESSED: begin
        if (!poll_i.pressed) begin
          mode_d       = bcgd_pkg::MODE_DEB_REL;
          entered_at_d = poll_i.now_ms;
        end else if (long_done) begin
          long_d                 = 1'b1;
          ev_d[bcgd_pkg::EV_LONG] = 1'b1;
          mode_d                 = bcgd_pkg::MODE_WAIT_REL;
          entered_at_d           = poll_i.now_ms;
        end
      end
      bcgd_pkg::MODE_WAIT_REL: begin
        if (!poll_i.pressed) begin
          mode_d       = bcgd_pkg::MODE_DEB_REL;
          entered_at_d = poll_i.now_ms;
        end
      end
      bcgd_pkg::MODE_DEB_REL: begin
        if (deb_done) begin
          held_d        = 1'b0;
          long_d        = 1'b0;
          released_at_d = poll_i.now_ms;
          entered_at_d  = poll_i.now_ms;
          // count above the limit fires multi-click at once
          if (clicks_inc > {1'b0, cfg_i.max_multi_clicks}) begin
            ev_d[bcgd_pkg::EV_MULTI] = 1'b1;
            clicks_d = '0;
            mode_d   = bcgd_pkg::MODE_IDLE;
          end else begin
            clicks_d = clicks_inc;
            mode_d   = bcgd_pkg::MODE_WAIT_NEXT;
          end
        end
      end
      bcgd_pkg::MODE_WAIT_NEXT: begin
        if (poll_i.pressed) begin
          mode_d       = bcgd_pkg::MODE_DEB_PRESS;
          entered_at_d = poll_i.now_ms;
        end else if (gap_done) begin
          case (clicks_q)
            9'd1:    ev_d[bcgd_pkg::EV_CLICK]  = 1'b1;
            9'd2:    ev_d[bcgd_pkg::EV_DOUBLE] = 1'b1;
            9'd3:    ev_d[bcgd_pkg::EV_MULTI]  = 1'b1;
            default: ;
          endcase
          clicks_d     = '0;
          mode_d       = bcgd_pkg::MODE_IDLE;
          entered_at_d = poll_i.now_ms;
        end
      end
      default: begin
        if (poll_i.pressed) begin
          mode_d       = bcgd_pkg::MODE_DEB_PRESS;
          entered_at_d = poll_i.now_ms;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= bcgd_pkg::MODE_IDLE;
      entered_at_q  <= '0;
      press_at_q    <= '0;
      released_at_q <= '0;
      clicks_q      <= '0;
      held_q        <= 1'b0;
      long_q        <= 1'b0;
      ev_q          <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      entered_at_q  <= entered_at_d;
      press_at_q    <= press_at_d;
      released_at_q <= released_at_d;
      clicks_q      <= clicks_d;
      held_q        <= held_d;
      long_q        <= long_d;
      ev_q          <= ev_d;
    end
  end

  // result word reflects the state after this poll
  assign result_o.is_pressed         = held_d;
  assign result_o.is_long_press      = long_d;
  assign result_o.click_count        = clicks_d;
  assign result_o.click_event        = ev_d[bcgd_pkg::EV_CLICK];
  assign result_o.double_click_event = ev_d[bcgd_pkg::EV_DOUBLE];
  assign result_o.long_press_event   = ev_d[bcgd_pkg::EV_LONG];
  assign result_o.multi_click_event  = ev_d[bcgd_pkg::EV_MULTI];

endmodule

// ===== src/button_click_gesture_detector_top.sv =====
// Path: an accepted poll word passes through the input register, then the
// result register, to its result word. Throughput: one poll word per cycle unless the
// sink stalls; the gesture state updates as a word moves from the input register to the
// result register, so back-to-back polls see each other's effect.
// Reset: asynchronous, active low; clears the gesture state, the sticky flags, both
// register valids, and loads the configuration defaults (50, 1000, 250, 3).
module button_click_gesture_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcgd_pkg::CfgDataW-1:0] cfg_wdata_i,
  bcgd_poll_if.sink                     poll_i,
  bcgd_result_if.source                 result_o
);

  bcgd_pkg::cfg_t    cfg;
  bcgd_pkg::poll_t   poll_q;
  bcgd_pkg::result_t step_res;
  bcgd_pkg::result_t res_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              out_free;
  logic              step;
  logic              accept;

  assign out_free = !out_vld_q || result_o.ready;
  assign step     = in_vld_q && out_free;
  assign poll_i.ready = !in_vld_q || step;
  assign accept   = poll_i.valid && poll_i.ready;

  bcgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcgd_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .poll_i   (poll_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      poll_q.pressed      <= poll_i.pressed;
      poll_q.now_ms       <= poll_i.now_ms;
      poll_q.clear_events <= poll_i.clear_events;
    end
    // hold the result word while the sink stalls
    if (step) begin
      res_q <= step_res;
    end
  end

  assign result_o.valid              = out_vld_q;
  assign result_o.is_pressed         = res_q.is_pressed;
  assign result_o.is_long_press      = res_q.is_long_press;
  assign result_o.click_count        = res_q.click_count;
  assign result_o.click_event        = res_q.click_event;
  assign result_o.double_click_event = res_q.double_click_event;
  assign result_o.long_press_event   = res_q.long_press_event;
  assign result_o.multi_click_event  = res_q.multi_click_event;

endmodule

// ===== src/bcgd_checker.sv =====
module bcgd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        is_pressed_i,
  input logic                        is_long_press_i,
  input logic [bcgd_pkg::CountW-1:0] click_count_i,
  input logic                        long_press_event_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(click_count_i)
      && $stable(is_pressed_i) && $stable(long_press_event_i))
    else $error("stalled result word changed");

  // a long press is only reported while the button is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_long_press_i |-> is_pressed_i)
    else $error("long press without debounced hold");

  // a fresh result word must trace back to an accepted poll word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without a poll word");

  // the long press flag rises only on the word that starts the long press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && $past(out_valid_i) && $rose(long_press_event_i) |-> is_long_press_i)
    else $error("long press flag raised outside a long press");

endmodule

bind button_click_gesture_detector_top bcgd_checker u_bcgd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (poll_i.valid),
  .in_ready_i         (poll_i.ready),
  .out_valid_i        (result_o.valid),
  .out_ready_i        (result_o.ready),
  .is_pressed_i       (result_o.is_pressed),
  .is_long_press_i    (result_o.is_long_press),
  .click_count_i      (result_o.click_count),
  .long_press_event_i (result_o.long_press_event)
);

// ===== bench/click_gesture_checker.sv =====
module click_gesture_checker import bcgd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  bcgd_poll_if                poll_mon,
  bcgd_result_if              result_mon,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mode_e             mode;
    logic [TimeW-1:0]  entered_at;
    logic [TimeW-1:0]  press_at;
    logic [TimeW-1:0]  release_at;
    logic [CountW-1:0] clicks;
    logic              held;
    logic              long_hold;
    logic [EvW-1:0]    flags;
  } gesture_t;

  gesture_t    gesture;
  cfg_t        timing;
  poll_t       poll_word;
  result_t     got;
  result_t     want;
  result_t     due_word;
  result_t     due_words[$];
  int unsigned mismatches;

  function automatic gesture_t next_gesture(gesture_t s, cfg_t c, poll_t p);
    logic [TimeW-1:0] since_entry;
    logic [TimeW-1:0] held_for;
    logic [TimeW-1:0] since_release;
    mode_e            nxt;
    since_entry   = p.now_ms - s.entered_at;
    held_for      = p.now_ms - s.press_at;
    since_release = p.now_ms - s.release_at;
    nxt           = s.mode;
    // the clear lands before this poll can raise anything
    if (p.clear_events) s.flags = '0;
    case (s.mode)
      MODE_DEB_PRESS: begin
        if (since_entry >= c.debounce_ms) begin
          if (p.pressed) begin
            s.press_at = p.now_ms;
            s.held     = 1'b1;
            nxt        = MODE_PRESSED;
          end else begin
            nxt = MODE_IDLE;
          end
        end
      end
      MODE_PRESSED: begin
        if (!p.pressed) begin
          nxt = MODE_DEB_REL;
        end else if (held_for >= c.long_press_ms) begin
          s.long_hold       = 1'b1;
          s.flags[EV_LONG]  = 1'b1;
          nxt               = MODE_WAIT_REL;
        end
      end
      MODE_WAIT_REL: begin
        if (!p.pressed) nxt = MODE_DEB_REL;
      end
      MODE_DEB_REL: begin
        if (since_entry >= c.debounce_ms) begin
          s.held       = 1'b0;
          s.long_hold  = 1'b0;
          s.release_at = p.now_ms;
          s.clicks     = s.clicks + 1'b1;
          if (s.clicks > c.max_multi_clicks) begin
            s.flags[EV_MULTI] = 1'b1;
            s.clicks          = '0;
            nxt               = MODE_IDLE;
          end else begin
            nxt = MODE_WAIT_NEXT;
          end
        end
      end
      MODE_WAIT_NEXT: begin
        if (p.pressed) begin
          nxt = MODE_DEB_PRESS;
        end else if (since_release >= c.double_click_ms) begin
          case (s.clicks)
            9'd1:    s.flags[EV_CLICK]  = 1'b1;
            9'd2:    s.flags[EV_DOUBLE] = 1'b1;
            9'd3:    s.flags[EV_MULTI]  = 1'b1;
            default: ;
          endcase
          s.clicks = '0;
          nxt      = MODE_IDLE;
        end
      end
      default: begin
        if (p.pressed) nxt = MODE_DEB_PRESS;
      end
    endcase
    // every change of mode restarts the elapsed-time reference
    if (nxt != s.mode) begin
      s.mode       = nxt;
      s.entered_at = p.now_ms;
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gesture    = '{MODE_IDLE, '0, '0, '0, '0, 1'b0, 1'b0, '0};
      timing     = '{DebounceRst, LongPressRst, DoubleRst, MaxMultiRst};
      mismatches = 0;
      due_words.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // retire before predicting, so a new poll never pairs with an older word
      if (result_mon.valid && result_mon.ready) begin
        got.is_pressed         = result_mon.is_pressed;
        got.is_long_press      = result_mon.is_long_press;
        got.click_count        = result_mon.click_count;
        got.click_event        = result_mon.click_event;
        got.double_click_event = result_mon.double_click_event;
        got.long_press_event   = result_mon.long_press_event;
        got.multi_click_event  = result_mon.multi_click_event;
        if (due_words.size() == 0) begin
          report_mismatch("result word with no poll outstanding");
        end else begin
          want = due_words.pop_front();
          if (got.is_pressed !== want.is_pressed)
            report_mismatch($sformatf("is_pressed got %0d, expected %0d",
                                      got.is_pressed, want.is_pressed));
          if (got.is_long_press !== want.is_long_press)
            report_mismatch($sformatf("is_long_press got %0d, expected %0d",
                                      got.is_long_press, want.is_long_press));
          if (got.click_count !== want.click_count)
            report_mismatch($sformatf("click_count got %0d, expected %0d",
                                      got.click_count, want.click_count));
          if (got.click_event !== want.click_event)
            report_mismatch($sformatf("click_event got %0d, expected %0d",
                                      got.click_event, want.click_event));
          if (got.double_click_event !== want.double_click_event)
            report_mismatch($sformatf("double_click_event got %0d, expected %0d",
                                      got.double_click_event, want.double_click_event));
          if (got.long_press_event !== want.long_press_event)
            report_mismatch($sformatf("long_press_event got %0d, expected %0d",
                                      got.long_press_event, want.long_press_event));
          if (got.multi_click_event !== want.multi_click_event)
            report_mismatch($sformatf("multi_click_event got %0d, expected %0d",
                                      got.multi_click_event, want.multi_click_event));
        end
      end
      if (poll_mon.valid && poll_mon.ready) begin
        poll_word.pressed      = poll_mon.pressed;
        poll_word.now_ms       = poll_mon.now_ms;
        poll_word.clear_events = poll_mon.clear_events;
        gesture = next_gesture(gesture, timing, poll_word);
        due_word.is_pressed         = gesture.held;
        due_word.is_long_press      = gesture.long_hold;
        due_word.click_count        = gesture.clicks;
        due_word.click_event        = gesture.flags[EV_CLICK];
        due_word.double_click_event = gesture.flags[EV_DOUBLE];
        due_word.long_press_event   = gesture.flags[EV_LONG];
        due_word.multi_click_event  = gesture.flags[EV_MULTI];
        due_words.push_back(due_word);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:   timing.debounce_ms      = cfg_wdata_i;
          CFG_LONG_PRESS: timing.long_press_ms    = cfg_wdata_i;
          CFG_DOUBLE:     timing.double_click_ms  = cfg_wdata_i;
          CFG_MAX_MULTI:  timing.max_multi_clicks = cfg_wdata_i[MaxW-1:0];
          default: ;
        endcase
      end
      pending_o    <= due_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcgd_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic [TimeW-1:0]    t_now;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         quiet_cycles  = 0;
  int unsigned         send_idle_pct = 10;
  int unsigned         recv_idle_pct = 69;
  int unsigned         n_sent        = 0;
  int unsigned         deb, lng, dbl;

  bcgd_poll_if   poll_ch ();
  bcgd_result_if res_ch ();

  button_click_gesture_detector_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .poll_i      (poll_ch.sink),
    .result_o    (res_ch.source)
  );

  click_gesture_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .poll_mon     (poll_ch),
    .result_mon   (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic pick_clear();
    return ($urandom_range(99, 0) < 12);
  endfunction

  task automatic send_poll(input logic lvl, input logic [TimeW-1:0] now_v, input logic clr);
    int unsigned gap;
    if (n_sent == 480) begin
      send_idle_pct = 69;
      recv_idle_pct = 10;
    end else if (n_sent == 960) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    poll_ch.valid        <= 1'b1;
    poll_ch.pressed      <= lvl;
    poll_ch.now_ms       <= now_v;
    poll_ch.clear_events <= clr;
    @(posedge clk_i);
    while (poll_ch.ready !== 1'b1) @(posedge clk_i);
    n_sent++;
  endtask

  // hold off until every word in flight has been retired
  task automatic wait_idle();
    poll_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_config(input int unsigned d, input int unsigned l,
                            input int unsigned b, input int unsigned m);
    wait_idle();
    deb  = d;
    lng  = l;
    dbl  = b;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= CfgDataW'(d);
    @(posedge clk_i);
    cfg_idx   <= CFG_LONG_PRESS;
    cfg_wdata <= CfgDataW'(l);
    @(posedge clk_i);
    cfg_idx   <= CFG_DOUBLE;
    cfg_wdata <= CfgDataW'(b);
    @(posedge clk_i);
    cfg_idx   <= CFG_MAX_MULTI;
    cfg_wdata <= CfgDataW'(m);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // click sequences scaled to the current timing, with glitches and noise mixed in
  task automatic run_gestures(input int unsigned count);
    int unsigned stop_at, kind, n_clicks, pick, hold, gap, poll_step, span;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      kind = $urandom_range(19, 0);
      if (kind == 0) wait_idle();
      if (kind <= 1) t_now = $urandom();
      if (kind == 2) begin
        repeat ($urandom_range(4, 1))
          send_poll(1'($urandom_range(1, 0)), $urandom(), pick_clear());
      end else begin
        n_clicks = $urandom_range(5, 1);
        for (int i = 0; i < n_clicks; i++) begin
          pick = $urandom_range(9, 0);
          if (pick < 2) hold = $urandom_range(deb, 0);
          else if (pick < 8) hold = deb + $urandom_range(lng / 2 + 1, 1);
          else hold = deb + lng + $urandom_range(lng / 4 + 20, 1);
          if (i + 1 < n_clicks) gap = deb + $urandom_range(dbl / 2 + 1, 1);
          else gap = deb + dbl + $urandom_range(dbl / 2 + 50, 1);
          poll_step = (hold + gap) / $urandom_range(10, 3);
          if (poll_step == 0) poll_step = 1;
          span = 0;
          do begin
            send_poll(1'b1, t_now, pick_clear());
            t_now += poll_step;
            span  += poll_step;
          end while (span < hold);
          span = 0;
          do begin
            send_poll(1'b0, t_now, pick_clear());
            t_now += poll_step;
            span  += poll_step;
          end while (span < gap);
        end
      end
    end
  endtask

  initial begin
    poll_ch.valid        = 1'b0;
    poll_ch.pressed      = 1'b0;
    poll_ch.now_ms       = '0;
    poll_ch.clear_events = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_DEBOUNCE;
    cfg_wdata            = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: 50 ms debounce, 1000 ms long press, 250 ms gap
    send_poll(1'b0, 32'h0000_0000, 1'b1);
    send_poll(1'b0, 32'hFFFF_FFFF, 1'b0);
    t_now = 32'hFFFF_FFF0;
    send_poll(1'b1, t_now, 1'b0);
    send_poll(1'b1, t_now + 49, 1'b0);
    t_now += 50;
    send_poll(1'b1, t_now, 1'b0);            // debounce met across the wrap
    send_poll(1'b1, t_now + 999, 1'b0);
    send_poll(1'b1, t_now + 1000, 1'b0);     // long press
    send_poll(1'b0, t_now + 1010, 1'b0);
    send_poll(1'b1, t_now + 1020, 1'b0);     // bounce inside release debounce
    t_now += 1060;
    send_poll(1'b0, t_now, 1'b0);
    send_poll(1'b1, t_now + 100, 1'b0);
    send_poll(1'b0, t_now + 150, 1'b0);      // press fails debounce, count kept
    send_poll(1'b1, t_now + 200, 1'b0);
    send_poll(1'b1, t_now + 250, 1'b0);
    send_poll(1'b0, t_now + 300, 1'b0);
    t_now += 350;
    send_poll(1'b0, t_now, 1'b0);
    send_poll(1'b0, t_now + 249, 1'b0);
    send_poll(1'b0, t_now + 250, 1'b0);      // double click closes
    send_poll(1'b0, t_now + 260, 1'b1);
    t_now += 300;

    set_config(5, 40, 30, 3);
    run_gestures(160);
    set_config(0, 0, 0, 0);
    run_gestures(60);

    // drive the click count past the 255 limit in one unbroken sequence
    set_config(0, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (4) begin
      t_now += 32'h2_0000;
      send_poll(1'b0, t_now, pick_clear());
    end
    for (int i = 0; i < 5; i++) begin
      t_now += 32'h2_0000;
      send_poll(i < 2, t_now, pick_clear());
    end
    repeat (256) begin
      for (int i = 0; i < 4; i++) begin
        t_now += $urandom_range(40, 0);
        send_poll(i < 2, t_now, pick_clear());
      end
    end

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_gestures(60);
    set_config(20, 100, 60, 1);
    run_gestures(120);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
